// ===== rtl/lgcd_pkg.sv =====
package lgcd_pkg;

	typedef logic [7:0] row_t;
	typedef row_t [7:0] plane_t;

	typedef struct packed {
		plane_t      on;
		plane_t      dim1;
		plane_t      dim2;
		logic [3:0]  level;
		logic        awake;
		logic [7:0]  opcode;
		logic [6:0]  left;
		logic [7:0]  held;
	} grid_state_t;

	typedef struct packed {
		logic done;
		logic bad;
	} step_flags_t;

	localparam logic [7:0] OP_QUERY     = 8'h00;
	localparam logic [7:0] OP_SLEEP     = 8'h01;
	localparam logic [7:0] OP_WAKE      = 8'h02;
	localparam logic [7:0] OP_CELL_CLR  = 8'h10;
	localparam logic [7:0] OP_CELL_SET  = 8'h11;
	localparam logic [7:0] OP_ALL_OFF   = 8'h12;
	localparam logic [7:0] OP_ALL_ON    = 8'h13;
	localparam logic [7:0] OP_MAP       = 8'h14;
	localparam logic [7:0] OP_ROW       = 8'h15;
	localparam logic [7:0] OP_COL       = 8'h16;
	localparam logic [7:0] OP_INTENSITY = 8'h17;
	localparam logic [7:0] OP_LVL_CELL  = 8'h18;
	localparam logic [7:0] OP_LVL_ALL   = 8'h19;
	localparam logic [7:0] OP_LVL_MAP   = 8'h1A;
	localparam logic [7:0] OP_LVL_ROW   = 8'h1B;
	localparam logic [7:0] OP_LVL_COL   = 8'h1C;
	localparam logic [7:0] OP_KEYPAD    = 8'h20;

	localparam logic [3:0] LEVEL_RESET = 4'd15;

	localparam grid_state_t STATE_RESET = '{
		on:     '0,
		dim1:   '0,
		dim2:   '0,
		level:  LEVEL_RESET,
		awake:  1'b1,
		opcode: '0,
		left:   '0,
		held:   '0
	};

	// packet length in bytes including the opcode, 0 for unknown codes
	function automatic logic [6:0] pkt_len(input logic [7:0] code);
		logic [6:0] len;
		unique case (code) inside
			OP_QUERY, OP_SLEEP, OP_WAKE, OP_KEYPAD, OP_ALL_OFF, OP_ALL_ON: len = 7'd1;
			OP_CELL_CLR, OP_CELL_SET, OP_INTENSITY, OP_LVL_ALL:           len = 7'd2;
			OP_ROW, OP_COL, OP_LVL_CELL:                                   len = 7'd3;
			OP_MAP:                                                        len = 7'd9;
			OP_LVL_MAP:                                                    len = 7'd65;
			OP_LVL_ROW, OP_LVL_COL:                                        len = 7'd10;
			default:                                                       len = 7'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/lgcd_exec.sv =====
module lgcd_exec (
	input  lgcd_pkg::grid_state_t st,
	input  logic                  take_byte,
	input  logic [7:0]            byte_value,
	output lgcd_pkg::grid_state_t st_n,
	output lgcd_pkg::step_flags_t flags
);
	import lgcd_pkg::*;

	plane_t     on_set, on_clr, lv_m;
	logic [7:0] row_wr;
	logic [6:0] len_b, len_c, k, km1;
	logic [1:0] lv;
	logic       lv_ok;
	logic [7:0] d1_set, d2_set;

	assign len_b = pkt_len(byte_value);
	assign len_c = pkt_len(st.opcode);
	assign k     = len_c - 7'd1 - st.left;
	assign km1   = k - 7'd1;
	assign lv    = byte_value[1:0];
	assign lv_ok = (byte_value[7:2] == 6'd0);

	always_comb begin
		st_n   = st;
		flags  = '0;
		on_set = '0;
		on_clr = '0;
		lv_m   = '0;
		row_wr = '0;

		if (take_byte) begin
			if (st.left == 7'd0) begin
				if (len_b == 7'd0) begin
					flags.bad = 1'b1;
				end else if (len_b == 7'd1) begin
					flags.done = 1'b1;
					case (byte_value)
						OP_SLEEP:   st_n.awake = 1'b0;
						OP_WAKE:    st_n.awake = 1'b1;
						OP_ALL_OFF: on_clr = '1;
						OP_ALL_ON:  on_set = '1;
						default:    ;
					endcase
				end else begin
					st_n.opcode = byte_value;
					st_n.left   = len_b - 7'd1;
				end
			end else begin
				st_n.left  = st.left - 7'd1;
				flags.done = (st.left == 7'd1);
				unique case (st.opcode)
					OP_CELL_CLR: begin
						if (!byte_value[3] && !byte_value[7])
							on_clr[byte_value[2:0]][byte_value[6:4]] = 1'b1;
					end
					OP_CELL_SET: begin
						if (!byte_value[3] && !byte_value[7])
							on_set[byte_value[2:0]][byte_value[6:4]] = 1'b1;
					end
					OP_MAP: begin
						if (k[6:3] == 4'd0)
							row_wr[k[2:0]] = 1'b1;
					end
					OP_ROW: begin
						if (k == 7'd0)
							st_n.held = byte_value;
						else if (st.held[7:3] == 5'd0)
							row_wr[st.held[2:0]] = 1'b1;
					end
					OP_COL: begin
						if (k == 7'd0) begin
							st_n.held = byte_value;
						end else if (st.held[7:3] == 5'd0) begin
							for (int r = 0; r < 8; r++) begin
								on_set[r][st.held[2:0]] = byte_value[r];
								on_clr[r][st.held[2:0]] = !byte_value[r];
							end
						end
					end
					OP_INTENSITY: st_n.level = byte_value[3:0];
					OP_LVL_CELL: begin
						if (k == 7'd0)
							st_n.held = byte_value;
						else if (!st.held[3] && !st.held[7])
							lv_m[st.held[2:0]][st.held[6:4]] = 1'b1;
					end
					OP_LVL_ALL: lv_m = '1;
					OP_LVL_MAP: begin
						if (k[6] == 1'b0)
							lv_m[k[5:3]][k[2:0]] = 1'b1;
					end
					OP_LVL_ROW: begin
						if (k == 7'd0)
							st_n.held = byte_value;
						else if (st.held[7:3] == 5'd0 && km1[6:3] == 4'd0)
							lv_m[st.held[2:0]][km1[2:0]] = 1'b1;
					end
					OP_LVL_COL: begin
						if (k == 7'd0)
							st_n.held = byte_value;
						else if (st.held[7:3] == 5'd0 && km1[6:3] == 4'd0)
							lv_m[km1[2:0]][st.held[2:0]] = 1'b1;
					end
					default: ;
				endcase
			end
		end

		if (!lv_ok)
			lv_m = '0;

		d1_set = (lv == 2'd1 || lv == 2'd2) ? 8'hFF : 8'h00;
		d2_set = (lv == 2'd1) ? 8'hFF : 8'h00;

		for (int r = 0; r < 8; r++) begin
			if (lv == 2'd0)
				on_clr[r] = on_clr[r] | lv_m[r];
			else
				on_set[r] = on_set[r] | lv_m[r];
			st_n.on[r] = row_wr[r] ? byte_value : ((st.on[r] & ~on_clr[r]) | on_set[r]);
			st_n.dim1[r] = (st.dim1[r] & ~lv_m[r]) | (lv_m[r] & d1_set);
			st_n.dim2[r] = (st.dim2[r] & ~lv_m[r]) | (lv_m[r] & d2_set);
		end
	end

endmodule

// ===== rtl/led_grid_command_decoder_core.sv =====
// Channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// cmd      | cmd_valid / cmd_stall | op, byte_value, read_row
// res      | res_valid / res_stall | packet_done, bad_opcode, row_on, row_dim_one,
//          |                       | row_dim_two, level_index, is_awake
//
// One item per cycle while res_stall is low, through the input and result registers.
// The grid planes and parser update in the cycle the item moves into the result register.
// cmd_stall rises only when the input register is full and the result register is held.
// arst_n clears the planes, parser and valid flags; intensity resets to 15, awake to 1.
module led_grid_command_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic       op,
	input  logic [7:0] byte_value,
	input  logic [2:0] read_row,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       packet_done,
	output logic       bad_opcode,
	output logic [7:0] row_on,
	output logic [7:0] row_dim_one,
	output logic [7:0] row_dim_two,
	output logic [3:0] level_index,
	output logic       is_awake
);
	import lgcd_pkg::*;

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic [2:0]  row_s1;
	logic        advance;

	grid_state_t state_q, state_n;
	step_flags_t flags;

	logic        res_valid_q;
	logic        done_q, bad_q;
	logic [7:0]  on_q, dim1_q, dim2_q;
	logic [3:0]  level_q;
	logic        awake_q;

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			op_s1   <= op;
			byte_s1 <= byte_value;
			row_s1  <= read_row;
		end
	end

	lgcd_exec u_exec (
		.st         (state_q),
		.take_byte  (!op_s1),
		.byte_value (byte_s1),
		.st_n       (state_n),
		.flags      (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_n;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q  <= flags.done;
			bad_q   <= flags.bad;
			on_q    <= state_n.on[row_s1];
			dim1_q  <= state_n.dim1[row_s1];
			dim2_q  <= state_n.dim2[row_s1];
			level_q <= state_n.level;
			awake_q <= state_n.awake;
		end
	end

	assign res_valid   = res_valid_q;
	assign packet_done = done_q;
	assign bad_opcode  = bad_q;
	assign row_on      = on_q;
	assign row_dim_one = dim1_q;
	assign row_dim_two = dim2_q;
	assign level_index = level_q;
	assign is_awake    = awake_q;

`ifndef SYNTHESIS
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.left <= 7'd64)
		else $error("bytes left out of range");

	a_busy_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.left != 7'd0 |-> pkt_len(state_q.opcode) > state_q.left)
		else $error("parser busy without a multi-byte opcode");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(done_q && bad_q))
		else $error("packet_done and bad_opcode both set");

	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result lost after advance");

	a_readonly_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 |=> !done_q && !bad_q && $stable(state_q))
		else $error("read item changed state");
`endif

endmodule
